### sv/cpn_pkg.sv
// Shared constants and the beat type carried along the cell chain.
package cpn_pkg;

    localparam int SampleWidth  = 16;
    localparam int FractionBits = 15;
    localparam int OutBits      = FractionBits + 1;
    localparam int ProdWidth    = 2 * SampleWidth;
    localparam int MagWidth     = ProdWidth;
    localparam int RadWidth     = 2 * MagWidth;
    localparam int RemWidth     = MagWidth + 3;
    localparam int DivWidth     = MagWidth + 1;
    localparam int SqrtCells    = MagWidth;
    localparam int DivCells     = FractionBits + 1;

    typedef struct packed {
        logic                nre;
        logic                nim;
        logic [MagWidth-1:0] are;
        logic [MagWidth-1:0] aim;
        logic [RadWidth-1:0] rad;
        logic [RemWidth-1:0] rem;
        logic [MagWidth-1:0] root;
        logic [DivWidth-1:0] dre;
        logic [DivWidth-1:0] dim;
        logic [OutBits-1:0]  qre;
        logic [OutBits-1:0]  qim;
    } t_beat;

endpackage

### sv/cross_power_phase_normalizer_unit.sv
// Top level of the cross-power phase normaliser for phase correlation.
// The slave channel takes one frequency-bin pair per beat: tdata holds
// ref_re, ref_im, smp_re and smp_im, sixteen bits each, from the lowest bit up.
// The master channel gives one beat per input beat: tdata holds phase_re and
// phase_im as Q1.15 values, and tuser carries the zero-magnitude flag.
// A beat passes a four-stage front end (products, sums, squares, magnitude
// squared), a row of 32 square-root cells, one root bit each, a row of 16
// division cells, one quotient bit of both parts each, and an output stage.
// Throughput is one beat per cycle while the master side keeps taking
// results; each stage holds one beat.
// Every stage moves on when the stage after it is empty or moving, so the
// block keeps accepting beats while a result waits, until the row is full.
// When the receiver stalls, results hold on the master side unchanged.
// Reset clears every stage's valid flag; otherwise no beat is lost or created.
module cross_power_phase_normalizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // ref_re, ref_im, smp_re, smp_im
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // phase_re, phase_im
    output logic        m_axis_tuser    // zero_magnitude
);
    import cpn_pkg::*;

    localparam int Cells = SqrtCells + DivCells;

    logic  v   [0:Cells];
    logic  rdy [0:Cells];
    t_beat bt  [0:Cells];

    cpn_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_ref_re (s_axis_tdata[15:0]),
        .i_ref_im (s_axis_tdata[31:16]),
        .i_smp_re (s_axis_tdata[47:32]),
        .i_smp_im (s_axis_tdata[63:48]),
        .o_valid  (v[0]),
        .i_ready  (rdy[0]),
        .o_beat   (bt[0])
    );

    for (genvar k = 0; k < SqrtCells; k++) begin : g_sqrt
        cpn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[k]),
            .o_ready (rdy[k]),
            .i_beat  (bt[k]),
            .o_valid (v[k+1]),
            .i_ready (rdy[k+1]),
            .o_beat  (bt[k+1])
        );
    end

    for (genvar k = SqrtCells; k < Cells; k++) begin : g_div
        cpn_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[k]),
            .o_ready (rdy[k]),
            .i_beat  (bt[k]),
            .o_valid (v[k+1]),
            .i_ready (rdy[k+1]),
            .o_beat  (bt[k+1])
        );
    end

    cpn_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (v[Cells]),
        .o_ready    (rdy[Cells]),
        .i_beat     (bt[Cells]),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_phase_re (m_axis_tdata[15:0]),
        .o_phase_im (m_axis_tdata[31:16]),
        .o_zero     (m_axis_tuser)
    );

endmodule

### sv/cpn_front.sv
// Front end: cross-power products, sum, squares and squared magnitude.
module cpn_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [cpn_pkg::SampleWidth-1:0] i_ref_re,
    input  logic signed [cpn_pkg::SampleWidth-1:0] i_ref_im,
    input  logic signed [cpn_pkg::SampleWidth-1:0] i_smp_re,
    input  logic signed [cpn_pkg::SampleWidth-1:0] i_smp_im,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output cpn_pkg::t_beat                         o_beat
);
    import cpn_pkg::*;

    logic                        r_v1, r_v2, r_v3, r_v4;
    logic                        rdy1, rdy2, rdy3, rdy4;
    logic signed [ProdWidth-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [ProdWidth:0]   n_cre, n_cim;
    logic                        r_nre2, r_nim2, r_nre3, r_nim3;
    logic [MagWidth-1:0]         r_are2, r_aim2, r_are3, r_aim3;
    logic [RadWidth-1:0]         r_sq_re, r_sq_im;
    t_beat                       r_beat;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v4;
    assign o_beat  = r_beat;

    assign n_cre = ProdWidth'(r_p0) + ProdWidth'(r_p1);
    assign n_cim = ProdWidth'(r_p2) - ProdWidth'(r_p3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_p0 <= i_smp_re * i_ref_re;
            r_p1 <= i_smp_im * i_ref_im;
            r_p2 <= i_smp_im * i_ref_re;
            r_p3 <= i_smp_re * i_ref_im;
        end
        if (rdy2 && r_v1) begin
            r_nre2 <= n_cre[ProdWidth];
            r_nim2 <= n_cim[ProdWidth];
            r_are2 <= n_cre[ProdWidth] ? MagWidth'(-n_cre) : MagWidth'(n_cre);
            r_aim2 <= n_cim[ProdWidth] ? MagWidth'(-n_cim) : MagWidth'(n_cim);
        end
        if (rdy3 && r_v2) begin
            r_nre3  <= r_nre2;
            r_nim3  <= r_nim2;
            r_are3  <= r_are2;
            r_aim3  <= r_aim2;
            r_sq_re <= r_are2 * r_are2;
            r_sq_im <= r_aim2 * r_aim2;
        end
        if (rdy4 && r_v3) begin
            r_beat.nre  <= r_nre3;
            r_beat.nim  <= r_nim3;
            r_beat.are  <= r_are3;
            r_beat.aim  <= r_aim3;
            r_beat.rad  <= r_sq_re + r_sq_im;
            r_beat.rem  <= '0;
            r_beat.root <= '0;
            r_beat.dre  <= {1'b0, r_are3};
            r_beat.dim  <= {1'b0, r_aim3};
            r_beat.qre  <= '0;
            r_beat.qim  <= '0;
        end
    end

endmodule

### sv/cpn_sqrt_cell.sv
// Square-root cell: settles one bit of the floor square root.
module cpn_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cpn_pkg::t_beat i_beat,
    output logic           o_valid,
    input  logic           i_ready,
    output cpn_pkg::t_beat o_beat
);
    import cpn_pkg::*;

    logic                r_valid;
    t_beat               r_beat;
    t_beat               n_beat;
    logic [RemWidth-1:0] rem_t;
    logic [RemWidth-1:0] trial;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    assign rem_t = {i_beat.rem[RemWidth-3:0], i_beat.rad[RadWidth-1 -: 2]};
    assign trial = {1'b0, i_beat.root, 2'b01};

    always_comb begin
        n_beat     = i_beat;
        n_beat.rad = {i_beat.rad[RadWidth-3:0], 2'b00};
        if (rem_t >= trial) begin
            n_beat.rem  = rem_t - trial;
            n_beat.root = {i_beat.root[MagWidth-2:0], 1'b1};
        end else begin
            n_beat.rem  = rem_t;
            n_beat.root = {i_beat.root[MagWidth-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

endmodule

### sv/cpn_div_cell.sv
// Division cell: settles one quotient bit of both parts over the magnitude.
module cpn_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cpn_pkg::t_beat i_beat,
    output logic           o_valid,
    input  logic           i_ready,
    output cpn_pkg::t_beat o_beat
);
    import cpn_pkg::*;

    logic                r_valid;
    t_beat               r_beat;
    t_beat               n_beat;
    logic [DivWidth-1:0] den;
    logic                bre, bim;
    logic [DivWidth-1:0] dre_s, dim_s;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    assign den   = {1'b0, i_beat.root};
    assign bre   = i_beat.dre >= den;
    assign bim   = i_beat.dim >= den;
    assign dre_s = bre ? i_beat.dre - den : i_beat.dre;
    assign dim_s = bim ? i_beat.dim - den : i_beat.dim;

    always_comb begin
        n_beat     = i_beat;
        n_beat.dre = {dre_s[DivWidth-2:0], 1'b0};
        n_beat.dim = {dim_s[DivWidth-2:0], 1'b0};
        n_beat.qre = {i_beat.qre[OutBits-2:0], bre};
        n_beat.qim = {i_beat.qim[OutBits-2:0], bim};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

endmodule

### sv/cpn_back.sv
// Output stage: rounding, sign, saturation and the zero-magnitude case.
module cpn_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  cpn_pkg::t_beat                    i_beat,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [cpn_pkg::OutBits-1:0]      o_phase_re,
    output logic [cpn_pkg::OutBits-1:0]      o_phase_im,
    output logic                              o_zero
);
    import cpn_pkg::*;

    localparam logic [OutBits:0] PosMax = (OutBits+1)'((1 << FractionBits) - 1);
    localparam logic [OutBits:0] NegMax = (OutBits+1)'(1 << FractionBits);

    logic                r_valid;
    logic [OutBits-1:0]  r_re, r_im;
    logic                r_zero;
    logic [DivWidth-1:0] den;
    logic [OutBits:0]    qr_re, qr_im;
    logic [OutBits-1:0]  n_re, n_im;
    logic                zero;

    function automatic logic [OutBits-1:0] finish(input logic neg, input logic [OutBits:0] q);
        logic [OutBits:0] s;
        begin
            s = q;
            if (neg) begin
                if (s > NegMax) s = NegMax;
                s = -s;
            end else if (s > PosMax) begin
                s = PosMax;
            end
            finish = s[OutBits-1:0];
        end
    endfunction

    assign den   = {1'b0, i_beat.root};
    assign zero  = i_beat.root == '0;
    assign qr_re = {1'b0, i_beat.qre} + (OutBits+1)'(i_beat.dre >= den);
    assign qr_im = {1'b0, i_beat.qim} + (OutBits+1)'(i_beat.dim >= den);
    assign n_re  = zero ? '0 : finish(i_beat.nre, qr_re);
    assign n_im  = zero ? '0 : finish(i_beat.nim, qr_im);

    assign o_ready    = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_phase_re = r_re;
    assign o_phase_im = r_im;
    assign o_zero     = r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_re   <= n_re;
            r_im   <= n_im;
            r_zero <= zero;
        end
    end

endmodule

### verif/cross_power_phase_normalizer_unit_tb.sv
// Self-checking testbench for the cross-power phase normaliser over its stream ports.
`timescale 1ns / 1ps

module cross_power_phase_normalizer_unit_tb;
    import cpn_pkg::*;

    typedef struct packed {
        logic [OutBits-1:0] phase_re;
        logic [OutBits-1:0] phase_im;
        logic               zero_mag;
    } t_phasor;

    typedef struct {
        logic [15:0] ref_re;
        logic [15:0] ref_im;
        logic [15:0] smp_re;
        logic [15:0] smp_im;
        bit          has_known;
        t_phasor     known;
    } t_bin_row;

    localparam int NumRandom = 1300;
    localparam int CycleLimit = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    t_phasor     phasor_queue[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          rx_wait = 0;
    bit          sending_done = 1'b0;

    cross_power_phase_normalizer_unit dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [OutBits-1:0] scale_part(bit neg, logic [63:0] mag_part,
                                                       logic [63:0] root);
        logic [127:0] num;
        logic [127:0] quot;
        logic [127:0] rest;
        logic [127:0] lim;
        num = {64'd0, mag_part} << FractionBits;
        quot = num / root;
        rest = num % root;
        if (rest >= root - rest) quot = quot + 1;
        lim = 128'd1 << FractionBits;
        if (neg) begin
            if (quot > lim) quot = lim;
            quot = -quot;
        end else if (quot > lim - 1) begin
            quot = lim - 1;
        end
        return quot[OutBits-1:0];
    endfunction

    function automatic t_phasor cross_phasor(logic [15:0] rr, logic [15:0] ri,
                                             logic [15:0] sr, logic [15:0] si);
        longint  c_re;
        longint  c_im;
        logic [127:0] sq;
        logic [63:0]  root;
        logic [63:0]  trial;
        t_phasor res;
        c_re = longint'($signed(sr)) * $signed(rr) + longint'($signed(si)) * $signed(ri);
        c_im = longint'($signed(si)) * $signed(rr) - longint'($signed(sr)) * $signed(ri);
        sq = 128'(c_re * c_re) + 128'(c_im * c_im);
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (128'(trial) * 128'(trial) <= sq) root = trial;
        end
        if (root == 0) begin
            res.phase_re = '0;
            res.phase_im = '0;
            res.zero_mag = 1'b1;
        end else begin
            res.phase_re = scale_part(c_re < 0, c_re < 0 ? -c_re : c_re, root);
            res.phase_im = scale_part(c_im < 0, c_im < 0 ? -c_im : c_im, root);
            res.zero_mag = 1'b0;
        end
        return res;
    endfunction

    task automatic send_bin(t_bin_row row);
        t_phasor want;
        int      gap;
        gap = $urandom_range(0, 15) * ($urandom_range(0, 3) == 0 ? 0 : 1);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata <= {row.smp_im, row.smp_re, row.ref_im, row.ref_re};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        want = cross_phasor(row.ref_re, row.ref_im, row.smp_re, row.smp_im);
        if (row.has_known && want != row.known) begin
            $display("%0t: directed row predicted %h %h %b, table %h %h %b", $time,
                     want.phase_re, want.phase_im, want.zero_mag,
                     row.known.phase_re, row.known.phase_im, row.known.zero_mag);
            error_count++;
        end
        phasor_queue.push_back(row.has_known ? row.known : want);
    endtask

    function automatic t_bin_row mk(logic [15:0] rr, logic [15:0] ri, logic [15:0] sr,
                                    logic [15:0] si, bit k = 0, logic [15:0] pr = 0,
                                    logic [15:0] pi = 0, logic z = 0);
        t_bin_row row;
        row.ref_re = rr; row.ref_im = ri; row.smp_re = sr; row.smp_im = si;
        row.has_known = k;
        row.known.phase_re = pr; row.known.phase_im = pi; row.known.zero_mag = z;
        return row;
    endfunction

    // Receiver that waits a random number of cycles before each beat and checks it
    // against the oldest prediction.
    always @(posedge i_clk) begin
        t_phasor want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (phasor_queue.size() == 0) begin
                $display("%0t: unexpected beat %h %b", $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = phasor_queue.pop_front();
                if (m_axis_tdata[15:0] !== want.phase_re) begin
                    $display("%0t: phase_re expected %h actual %h", $time, want.phase_re,
                             m_axis_tdata[15:0]);
                    error_count++;
                end
                if (m_axis_tdata[31:16] !== want.phase_im) begin
                    $display("%0t: phase_im expected %h actual %h", $time, want.phase_im,
                             m_axis_tdata[31:16]);
                    error_count++;
                end
                if (m_axis_tuser !== want.zero_mag) begin
                    $display("%0t: zero_magnitude expected %b actual %b", $time,
                             want.zero_mag, m_axis_tuser);
                    error_count++;
                end
            end
        end
        if (m_axis_tvalid && m_axis_tready) begin
            rx_wait = $urandom_range(0, 15);
        end else if (rx_wait > 0) begin
            rx_wait--;
        end
        m_axis_tready <= (rx_wait == 0);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("** cross_power_phase_normalizer_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        t_bin_row dir_table[$];
        t_bin_row row;
        dir_table.push_back(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0, 1));
        dir_table.push_back(mk(16'h1234, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0, 1));
        dir_table.push_back(mk(16'h0000, 16'h0000, 16'h8000, 16'h7fff, 1, 0, 0, 1));
        dir_table.push_back(mk(16'h0001, 16'h0000, 16'h0001, 16'h0000, 1, 16'h7fff, 0, 0));
        dir_table.push_back(mk(16'h0001, 16'h0000, 16'hffff, 16'h0000, 1, 16'h8000, 0, 0));
        dir_table.push_back(mk(16'h0001, 16'h0000, 16'h0000, 16'h0001, 1, 0, 16'h7fff, 0));
        dir_table.push_back(mk(16'h0001, 16'h0000, 16'h0000, 16'hffff, 1, 0, 16'h8000, 0));
        dir_table.push_back(mk(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        dir_table.push_back(mk(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        dir_table.push_back(mk(16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
        dir_table.push_back(mk(16'h8000, 16'h0000, 16'h7fff, 16'h0000));
        dir_table.push_back(mk(16'hffff, 16'hffff, 16'h0001, 16'h0001));
        dir_table.push_back(mk(16'h0003, 16'h0004, 16'h0001, 16'h0000));
        dir_table.push_back(mk(16'h0001, 16'h0001, 16'h0001, 16'h0000));
        dir_table.push_back(mk(16'h5555, 16'haaaa, 16'haaaa, 16'h5555));
        dir_table.push_back(mk(16'h0001, 16'h0002, 16'h0003, 16'h0001));
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_table[i]) send_bin(dir_table[i]);
        for (int n = 0; n < NumRandom; n++) begin
            if (n == NumRandom / 2) begin
                s_axis_tvalid <= 1'b0;
                wait (phasor_queue.size() == 0);
            end
            case ($urandom_range(0, 3))
                0: row = mk(16'($urandom_range(0, 7) - 4), 16'($urandom_range(0, 7) - 4),
                            16'($urandom_range(0, 7) - 4), 16'($urandom_range(0, 7) - 4));
                1: row = mk($urandom_range(0, 1) ? 16'h8000 : 16'h7fff, 16'($urandom),
                            $urandom_range(0, 1) ? 16'h8000 : 16'h7fff, 16'($urandom));
                default: row = mk(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom));
            endcase
            send_bin(row);
            if ($urandom_range(0, 30) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (20) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        wait (phasor_queue.size() == 0);
        repeat (80) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** cross_power_phase_normalizer_unit: PASSED **");
        end else begin
            $display("** cross_power_phase_normalizer_unit: FAILED **");
        end
        $finish;
    end
endmodule

### files.f
sv/cpn_pkg.sv
sv/cpn_front.sv
sv/cpn_sqrt_cell.sv
sv/cpn_div_cell.sv
sv/cpn_back.sv
sv/cross_power_phase_normalizer_unit.sv
verif/cross_power_phase_normalizer_unit_tb.sv
